// ===== src/vmbae_pkg.sv =====
// Shared types and constants for the VM branch and ALU execute core.
`default_nettype none
package vmbae_pkg;

    localparam int unsigned PC_W            = 12;
    localparam int unsigned REG_W           = 8;
    localparam int unsigned REG_IDX_W       = 4;
    localparam int unsigned NUM_REGS        = 16;
    localparam int unsigned INSTR_W         = 16;
    localparam int unsigned STACK_DEPTH_DEF = 16;

    localparam logic [PC_W-1:0]    PC_RESET = 12'h200;
    localparam logic [PC_W-1:0]    PC_STEP  = 12'd2;
    localparam logic [PC_W-1:0]    PC_SKIP  = 12'd4;
    localparam logic [INSTR_W-1:0] RET_WORD = 16'h00EE;

    // Major opcode, top nibble of the instruction
    localparam logic [3:0] OP_SYS     = 4'h0;
    localparam logic [3:0] OP_JP      = 4'h1;
    localparam logic [3:0] OP_CALL    = 4'h2;
    localparam logic [3:0] OP_SE_IMM  = 4'h3;
    localparam logic [3:0] OP_SNE_IMM = 4'h4;
    localparam logic [3:0] OP_SE_REG  = 4'h5;
    localparam logic [3:0] OP_LD_IMM  = 4'h6;
    localparam logic [3:0] OP_ADD_IMM = 4'h7;
    localparam logic [3:0] OP_ALU     = 4'h8;

    // Register-register function, low nibble of an ALU instruction
    localparam logic [3:0] FN_MOV = 4'h0;
    localparam logic [3:0] FN_OR  = 4'h1;
    localparam logic [3:0] FN_AND = 4'h2;
    localparam logic [3:0] FN_XOR = 4'h3;

    // Result item, last field in the lowest bits
    typedef struct packed {
        logic                 unsupported;
        logic [REG_W-1:0]     reg_value;
        logic [REG_IDX_W-1:0] reg_index;
        logic                 reg_written;
        logic                 skipped;
        logic [PC_W-1:0]      next_pc;
    } result_t;

    localparam int unsigned RESULT_W = $bits(result_t);
    localparam int unsigned OUT_W    = ((RESULT_W + 7) / 8) * 8;

endpackage
`default_nettype wire

// ===== src/vm_branch_and_alu_execute_core.sv =====
// Top level: executes one branch/ALU instruction per request.
//
//  channel | dir | payload (lowest bit first)
//  --------+-----+------------------------------------------------------------
//  s_*     | in  | tdata: instruction[15:0]
//  m_*     | out | tdata: next_pc[11:0], skipped, reg_written, reg_index[3:0],
//          |     |        reg_value[7:0], unsupported, zero pad to 32 bits
//
// One instruction per cycle while the result side accepts: an input register
// feeds the execute logic, which loads the result register.
// Register file and return stack sit in registered-read RAMs addressed in the
// cycle before execute, with write forwarding. Reset sets the counter to 0x200, the
// stack pointer to STACK_DEPTH-1 and marks all stored entries as zero.
// A stalled result holds; the input register still takes a request if empty.
`default_nettype none
module vm_branch_and_alu_execute_core #(
    parameter int unsigned STACK_DEPTH = vmbae_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [vmbae_pkg::INSTR_W-1:0] s_tdata,  // instruction[15:0]
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // next_pc[11:0], skipped, reg_written, reg_index[3:0], reg_value[7:0],
    // unsupported, zero pad
    output logic [vmbae_pkg::OUT_W-1:0]     m_tdata
);

    localparam int unsigned SP_W  = $clog2(STACK_DEPTH);
    localparam int unsigned PC_W  = vmbae_pkg::PC_W;
    localparam int unsigned REG_W = vmbae_pkg::REG_W;
    localparam int unsigned IDX_W = vmbae_pkg::REG_IDX_W;
    localparam int unsigned NREGS = vmbae_pkg::NUM_REGS;
    localparam int unsigned PAD_W = vmbae_pkg::OUT_W - vmbae_pkg::RESULT_W;
    localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);

    // Input and output stages
    logic                             in_valid_reg;
    logic [vmbae_pkg::INSTR_W-1:0]    instr_reg;
    logic                             out_valid_reg;
    vmbae_pkg::result_t               result_reg;
    vmbae_pkg::result_t               result_next;
    logic                             load;
    logic                             fire;

    // Architectural state
    logic [PC_W-1:0]                  pc_reg;
    logic [PC_W-1:0]                  pc_next;
    logic [SP_W-1:0]                  sp_reg;
    logic [SP_W-1:0]                  sp_next;
    logic [SP_W-1:0]                  sp_inc;
    logic [SP_W-1:0]                  sp_dec;
    logic [NREGS-1:0]                 gr_valid_reg;
    logic [STACK_DEPTH-1:0]           st_valid_reg;

    // Register file ports
    logic                             gr_we;
    logic [IDX_W-1:0]                 gr_waddr;
    logic [REG_W-1:0]                 gr_wdata;
    logic [IDX_W-1:0]                 rx_addr;
    logic [IDX_W-1:0]                 ry_addr;
    logic [REG_W-1:0]                 rx_q;
    logic [REG_W-1:0]                 ry_q;
    logic                             rx_fwd_reg;
    logic                             ry_fwd_reg;
    logic                             rx_vld_reg;
    logic                             ry_vld_reg;
    logic [REG_W-1:0]                 gr_fwd_data_reg;
    logic [REG_W-1:0]                 vx;
    logic [REG_W-1:0]                 vy;

    // Return stack ports
    logic                             st_we;
    logic [PC_W-1:0]                  st_q;
    logic                             st_fwd_reg;
    logic                             st_vld_reg;
    logic [PC_W-1:0]                  st_fwd_data_reg;
    logic [PC_W-1:0]                  st_top;

    // Decoded fields
    logic [3:0]                       op;
    logic [IDX_W-1:0]                 fx;
    logic [3:0]                       fn;
    logic [REG_W-1:0]                 kk;
    logic [PC_W-1:0]                  nnn;
    logic                             skip;
    logic                             wr;
    logic                             unsup;
    logic                             is_call;
    logic                             is_ret;
    logic [REG_W-1:0]                 val;
    logic [PC_W-1:0]                  jump_pc;
    logic                             jump;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign load     = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, result_reg};

    assign op  = instr_reg[15:12];
    assign fx  = instr_reg[11:8];
    assign fn  = instr_reg[3:0];
    assign kk  = instr_reg[7:0];
    assign nnn = instr_reg[11:0];

    assign sp_inc = (sp_reg == SP_LAST) ? '0 : sp_reg + 1'b1;
    assign sp_dec = (sp_reg == '0) ? SP_LAST : sp_reg - 1'b1;

    // Read addresses are presented in the cycle before the execute stage uses them
    assign rx_addr = load ? s_tdata[11:8] : instr_reg[11:8];
    assign ry_addr = load ? s_tdata[7:4]  : instr_reg[7:4];

    assign vx     = rx_fwd_reg ? gr_fwd_data_reg : (rx_vld_reg ? rx_q : '0);
    assign vy     = ry_fwd_reg ? gr_fwd_data_reg : (ry_vld_reg ? ry_q : '0);
    assign st_top = st_fwd_reg ? st_fwd_data_reg : (st_vld_reg ? st_q : '0);

    // Execute
    always_comb
    begin
        skip    = 1'b0;
        wr      = 1'b0;
        unsup   = 1'b0;
        is_call = 1'b0;
        is_ret  = 1'b0;
        jump    = 1'b0;
        jump_pc = nnn;
        val     = '0;
        unique case (op)
            vmbae_pkg::OP_SYS:
            begin
                if (instr_reg == vmbae_pkg::RET_WORD)
                begin
                    is_ret  = 1'b1;
                    jump    = 1'b1;
                    jump_pc = st_top + vmbae_pkg::PC_STEP;
                end
                else
                begin
                    unsup = 1'b1;
                end
            end
            vmbae_pkg::OP_JP:
            begin
                jump = 1'b1;
            end
            vmbae_pkg::OP_CALL:
            begin
                is_call = 1'b1;
                jump    = 1'b1;
            end
            vmbae_pkg::OP_SE_IMM:
            begin
                skip = (vx == kk);
            end
            vmbae_pkg::OP_SNE_IMM:
            begin
                skip = (vx != kk);
            end
            vmbae_pkg::OP_SE_REG:
            begin
                if (fn == 4'h0)
                begin
                    skip = (vx == vy);
                end
                else
                begin
                    unsup = 1'b1;
                end
            end
            vmbae_pkg::OP_LD_IMM:
            begin
                wr  = 1'b1;
                val = kk;
            end
            vmbae_pkg::OP_ADD_IMM:
            begin
                wr  = 1'b1;
                val = vx + kk;
            end
            vmbae_pkg::OP_ALU:
            begin
                unique case (fn)
                    vmbae_pkg::FN_MOV:
                    begin
                        wr  = 1'b1;
                        val = vy;
                    end
                    vmbae_pkg::FN_OR:
                    begin
                        wr  = 1'b1;
                        val = vx | vy;
                    end
                    vmbae_pkg::FN_AND:
                    begin
                        wr  = 1'b1;
                        val = vx & vy;
                    end
                    vmbae_pkg::FN_XOR:
                    begin
                        wr  = 1'b1;
                        val = vx ^ vy;
                    end
                    default:
                    begin
                        unsup = 1'b1;
                    end
                endcase
            end
            default:
            begin
                unsup = 1'b1;
            end
        endcase

        if (skip)
        begin
            pc_next = pc_reg + vmbae_pkg::PC_SKIP;
        end
        else if (jump)
        begin
            pc_next = jump_pc;
        end
        else
        begin
            pc_next = pc_reg + vmbae_pkg::PC_STEP;
        end

        result_next.next_pc     = pc_next;
        result_next.skipped     = skip;
        result_next.reg_written = wr;
        result_next.reg_index   = wr ? fx : '0;
        result_next.reg_value   = wr ? val : '0;
        result_next.unsupported = unsup;
    end

    assign gr_we    = fire && wr;
    assign gr_waddr = fx;
    assign gr_wdata = val;
    assign st_we    = fire && is_call;

    always_comb
    begin
        priority if (fire && is_call)
        begin
            sp_next = sp_inc;
        end
        else if (fire && is_ret)
        begin
            sp_next = sp_dec;
        end
        else
        begin
            sp_next = sp_reg;
        end
    end

    vmbae_ram #(
        .WIDTH (REG_W),
        .DEPTH (NREGS)
    ) u_gr_x (
        .clk   (clk),
        .we    (gr_we),
        .waddr (gr_waddr),
        .wdata (gr_wdata),
        .raddr (rx_addr),
        .rdata (rx_q)
    );

    vmbae_ram #(
        .WIDTH (REG_W),
        .DEPTH (NREGS)
    ) u_gr_y (
        .clk   (clk),
        .we    (gr_we),
        .waddr (gr_waddr),
        .wdata (gr_wdata),
        .raddr (ry_addr),
        .rdata (ry_q)
    );

    vmbae_ram #(
        .WIDTH (PC_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (st_we),
        .waddr (sp_inc),
        .wdata (pc_reg),
        .raddr (sp_next),
        .rdata (st_q)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= vmbae_pkg::PC_RESET;
            sp_reg        <= SP_LAST;
            gr_valid_reg  <= '0;
            st_valid_reg  <= '0;
            rx_fwd_reg    <= 1'b0;
            ry_fwd_reg    <= 1'b0;
            rx_vld_reg    <= 1'b0;
            ry_vld_reg    <= 1'b0;
            st_fwd_reg    <= 1'b0;
            st_vld_reg    <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= load || (in_valid_reg && !fire);
            out_valid_reg <= fire || (out_valid_reg && !m_tready);
            sp_reg        <= sp_next;
            if (fire)
            begin
                pc_reg <= pc_next;
            end
            if (gr_we)
            begin
                gr_valid_reg[gr_waddr] <= 1'b1;
            end
            if (st_we)
            begin
                st_valid_reg[sp_inc] <= 1'b1;
            end
            rx_fwd_reg <= gr_we && (gr_waddr == rx_addr);
            ry_fwd_reg <= gr_we && (gr_waddr == ry_addr);
            rx_vld_reg <= gr_valid_reg[rx_addr];
            ry_vld_reg <= gr_valid_reg[ry_addr];
            st_fwd_reg <= st_we && (sp_inc == sp_next);
            st_vld_reg <= st_valid_reg[sp_next];
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            instr_reg <= s_tdata;
        end
        if (fire)
        begin
            result_reg <= result_next;
        end
        gr_fwd_data_reg <= gr_wdata;
        st_fwd_data_reg <= pc_reg;
    end

endmodule
`default_nettype wire

// ===== src/vmbae_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module vmbae_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== tb/vmbae_exec_checker.sv =====
// Watches both channels of the execute core, predicts each result and compares it.
`default_nettype none
module vmbae_exec_checker
    import vmbae_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    input  wire logic               s_tready,
    input  wire logic [INSTR_W-1:0] s_tdata,
    input  wire logic               m_tvalid,
    input  wire logic               m_tready,
    input  wire logic [OUT_W-1:0]   m_tdata,
    output int unsigned             errors,
    output int unsigned             outstanding
);

    logic [REG_W-1:0] vregs [NUM_REGS];
    logic [PC_W-1:0]  call_stack [STACK_DEPTH];
    int unsigned      stack_ptr;
    logic [PC_W-1:0]  pc;
    result_t          expected_results [$];
    int unsigned      fail_cnt;

    function automatic result_t execute_instr(input logic [INSTR_W-1:0] instr);
        result_t          r;
        logic [3:0]       major;
        logic [3:0]       x;
        logic [3:0]       y;
        logic [3:0]       fn;
        logic [7:0]       kk;
        logic             wr;
        logic [REG_W-1:0] val;
        major = instr[15:12];
        x     = instr[11:8];
        y     = instr[7:4];
        fn    = instr[3:0];
        kk    = instr[7:0];
        r     = '0;
        wr    = 1'b0;
        val   = '0;
        r.next_pc = pc + PC_STEP;
        case (major)
            OP_SYS:
            begin
                if (instr == RET_WORD)
                begin
                    r.next_pc = call_stack[stack_ptr] + PC_STEP;
                    stack_ptr = (stack_ptr + STACK_DEPTH - 1) % STACK_DEPTH;
                end
                else
                begin
                    r.unsupported = 1'b1;
                end
            end
            OP_JP:
            begin
                r.next_pc = instr[PC_W-1:0];
            end
            OP_CALL:
            begin
                stack_ptr = (stack_ptr + 1) % STACK_DEPTH;
                call_stack[stack_ptr] = pc;
                r.next_pc = instr[PC_W-1:0];
            end
            OP_SE_IMM:
            begin
                r.skipped = (vregs[x] == kk);
            end
            OP_SNE_IMM:
            begin
                r.skipped = (vregs[x] != kk);
            end
            OP_SE_REG:
            begin
                if (fn == '0)
                    r.skipped = (vregs[x] == vregs[y]);
                else
                    r.unsupported = 1'b1;
            end
            OP_LD_IMM:
            begin
                wr  = 1'b1;
                val = kk;
            end
            OP_ADD_IMM:
            begin
                wr  = 1'b1;
                val = vregs[x] + kk;
            end
            OP_ALU:
            begin
                wr = 1'b1;
                case (fn)
                    FN_MOV:  val = vregs[y];
                    FN_OR:   val = vregs[x] | vregs[y];
                    FN_AND:  val = vregs[x] & vregs[y];
                    FN_XOR:  val = vregs[x] ^ vregs[y];
                    default:
                    begin
                        wr            = 1'b0;
                        r.unsupported = 1'b1;
                    end
                endcase
            end
            default:
            begin
                r.unsupported = 1'b1;
            end
        endcase
        if (r.skipped)
            r.next_pc = pc + PC_SKIP;
        if (wr)
        begin
            vregs[x]      = val;
            r.reg_written = 1'b1;
            r.reg_index   = x;
            r.reg_value   = val;
        end
        pc = r.next_pc;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                vregs[i] = '0;
            for (int i = 0; i < STACK_DEPTH; i++)
                call_stack[i] = '0;
            stack_ptr = STACK_DEPTH - 1;
            pc        = PC_RESET;
            expected_results.delete();
            fail_cnt  = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(execute_instr(s_tdata));
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[RESULT_W-1:0]);
                if (expected_results.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                    begin
                        $write("unexpected result: next_pc=%h skipped=%b wr=%b ",
                               got.next_pc, got.skipped, got.reg_written);
                        $display("idx=%h val=%h unsup=%b",
                                 got.reg_index, got.reg_value, got.unsupported);
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.next_pc !== want.next_pc || got.skipped !== want.skipped ||
                        got.reg_written !== want.reg_written ||
                        got.reg_index !== want.reg_index ||
                        got.reg_value !== want.reg_value ||
                        got.unsupported !== want.unsupported)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                        begin
                            $write("mismatch: expected pc=%h skip=%b wr=%b ",
                                   want.next_pc, want.skipped, want.reg_written);
                            $write("idx=%h val=%h unsup=%b,",
                                   want.reg_index, want.reg_value, want.unsupported);
                            $display(" got pc=%h skip=%b wr=%b idx=%h val=%h unsup=%b",
                                     got.next_pc, got.skipped, got.reg_written,
                                     got.reg_index, got.reg_value, got.unsupported);
                        end
                    end
                end
            end
        end
        errors      <= fail_cnt;
        outstanding <= expected_results.size();
    end

endmodule
`default_nettype wire

// ===== tb/vm_branch_and_alu_execute_core_tb.sv =====
// Drives instruction requests into the execute core, applies back-pressure and gives the verdict.
`default_nettype none
module vm_branch_and_alu_execute_core_tb;
    import vmbae_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 950;
    localparam int unsigned QUIET_ITEMS  = 800;
    localparam int unsigned HOLD_CYCLES  = 64;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned CYCLE_LIMIT  = 300000;

    localparam logic [3:0] OP_SNE_REG = 4'h9;
    localparam logic [3:0] OP_SPECIAL = 4'hF;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [INSTR_W-1:0] s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;
    int unsigned        errors;
    int unsigned        outstanding;

    bit                 tx_quiet;
    bit                 rx_quiet;
    bit                 rx_hold_req;
    int unsigned        tx_gap_odds;
    int unsigned        issued;

    vm_branch_and_alu_execute_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    vmbae_exec_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("vm_branch_and_alu_execute_core_tb: errors");
        $finish;
    end

    // Result side: random stalls, stretches of full rate, one long hold on request.
    initial
    begin
        int unsigned hold_left;
        int unsigned stall_left;
        int unsigned run_left;
        hold_left  = 0;
        stall_left = 0;
        run_left   = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_left   = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (rx_quiet || run_left != 0)
            begin
                if (run_left != 0)
                    run_left--;
                m_tready <= 1'b1;
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                run_left = $urandom_range(20, 80);
                m_tready <= 1'b1;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_instr(input logic [INSTR_W-1:0] word);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge clk); while (!s_tready);
        issued++;
        if (!tx_quiet && tx_gap_odds != 0 && $urandom_range(1, tx_gap_odds) == 1)
        begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    function automatic logic [3:0] pick_reg();
        logic [3:0] r;
        if ($urandom_range(0, 1) == 0)
            r = 4'($urandom_range(0, 3));
        else
            r = 4'($urandom_range(0, 15));
        return r;
    endfunction

    function automatic logic [7:0] pick_imm();
        logic [7:0] v;
        case ($urandom_range(0, 5))
            0:       v = 8'h00;
            1:       v = 8'hFF;
            2:       v = 8'h01;
            default: v = 8'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    function automatic logic [INSTR_W-1:0] rand_instr();
        logic [3:0]      x;
        logic [3:0]      y;
        logic [3:0]      fn;
        logic [PC_W-1:0] addr;
        logic [INSTR_W-1:0] w;
        x    = pick_reg();
        y    = pick_reg();
        fn   = 4'($urandom_range(0, 3));
        addr = PC_W'($urandom_range(0, 4095));
        case ($urandom_range(0, 19))
            0, 1:    w = RET_WORD;
            2:       w = {OP_JP, addr};
            3, 4:    w = {OP_CALL, addr};
            5, 6:    w = {OP_SE_IMM, x, pick_imm()};
            7, 8:    w = {OP_SNE_IMM, x, pick_imm()};
            9:       w = {OP_SE_REG, x, y, 4'h0};
            10, 11:  w = {OP_LD_IMM, x, pick_imm()};
            12, 13:  w = {OP_ADD_IMM, x, pick_imm()};
            14, 15, 16: w = {OP_ALU, x, y, fn};
            default: w = INSTR_W'($urandom_range(0, 65535));
        endcase
        return w;
    endfunction

    task automatic random_block();
        int unsigned     n;
        logic [3:0]      x;
        logic [3:0]      y;
        logic [7:0]      kk;
        logic [PC_W-1:0] addr;
        x  = pick_reg();
        y  = pick_reg();
        kk = pick_imm();
        case ($urandom_range(0, 9))
            5:
            begin
                send_instr({OP_LD_IMM, x, kk});
                if ($urandom_range(0, 3) == 0)
                    kk = pick_imm();
                if ($urandom_range(0, 1) == 0)
                    send_instr({OP_SE_IMM, x, kk});
                else
                    send_instr({OP_SNE_IMM, x, kk});
            end
            6:
            begin
                send_instr({OP_ALU, y, x, FN_MOV});
                if ($urandom_range(0, 2) == 0)
                    send_instr({OP_ADD_IMM, y, pick_imm()});
                send_instr({OP_SE_REG, x, y, 4'h0});
            end
            7:
            begin
                n = $urandom_range(1, 20);
                repeat (n)
                begin
                    addr = PC_W'($urandom_range(0, 4095));
                    send_instr({OP_CALL, addr});
                    if ($urandom_range(0, 2) == 0)
                        send_instr(rand_instr());
                end
                repeat ($urandom_range(0, n + 3))
                    send_instr(RET_WORD);
            end
            8:
            begin
                repeat ($urandom_range(1, 4))
                    send_instr(INSTR_W'($urandom_range(0, 65535)));
            end
            9:
            begin
                addr = PC_W'($urandom_range(4088, 4095));
                send_instr({OP_JP, addr});
                repeat ($urandom_range(1, 6))
                    send_instr(rand_instr());
            end
            default:
            begin
                repeat ($urandom_range(1, 8))
                    send_instr(rand_instr());
            end
        endcase
    endtask

    initial
    begin
        int unsigned random_start;
        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        tx_quiet    = 1'b0;
        rx_quiet    = 1'b0;
        rx_hold_req = 1'b0;
        tx_gap_odds = 6;
        issued      = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        send_instr({OP_SYS, 12'h0E0});
        send_instr(RET_WORD);
        send_instr({OP_LD_IMM, 4'hA, 8'hFF});
        send_instr({OP_ADD_IMM, 4'hA, 8'h01});
        send_instr({OP_ADD_IMM, 4'hA, 8'hFF});
        send_instr({OP_LD_IMM, 4'hB, 8'h0F});
        send_instr({OP_ALU, 4'hA, 4'hB, FN_OR});
        send_instr({OP_ALU, 4'hA, 4'hB, FN_AND});
        send_instr({OP_ALU, 4'hA, 4'hB, FN_XOR});
        send_instr({OP_ALU, 4'hC, 4'hB, FN_MOV});
        send_instr({OP_SE_IMM, 4'hC, 8'h0F});
        send_instr({OP_SNE_IMM, 4'hC, 8'h0F});
        send_instr({OP_SNE_IMM, 4'hC, 8'h00});
        send_instr({OP_SE_REG, 4'hC, 4'hB, 4'h0});
        send_instr({OP_SE_REG, 4'hA, 4'h0, 4'h0});
        send_instr({OP_SE_REG, 4'hC, 4'hB, 4'hF});
        send_instr({OP_ALU, 4'hA, 4'hB, 4'h4});
        send_instr({OP_ALU, 4'hA, 4'hB, 4'hF});
        send_instr({OP_SPECIAL, 12'hFFF});
        send_instr({OP_SYS, 12'h000});
        send_instr({OP_CALL, 12'hFFE});
        send_instr({OP_SE_IMM, 4'hC, 8'h0F});
        send_instr(RET_WORD);
        send_instr({OP_JP, 12'h000});
        send_instr({OP_SNE_REG, 12'hABC});

        // hold the result side while requests keep coming, then drain
        tx_gap_odds = 0;
        rx_hold_req = 1'b1;
        random_start = issued;
        while (issued - random_start < 30)
            random_block();
        wait_all_results();

        while (issued - random_start < RANDOM_ITEMS)
        begin
            if (issued - random_start >= QUIET_ITEMS)
            begin
                tx_quiet = 1'b1;
                rx_quiet = 1'b1;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                tx_gap_odds = $urandom_range(0, 8);
            end
            random_block();
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("vm_branch_and_alu_execute_core_tb: clean");
        else
            $display("vm_branch_and_alu_execute_core_tb: errors");
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
src/vmbae_pkg.sv
src/vmbae_ram.sv
src/vm_branch_and_alu_execute_core.sv
tb/vmbae_exec_checker.sv
tb/vm_branch_and_alu_execute_core_tb.sv
